/* design/lmlt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcd mode and line timing package
// types and timing constants shared by the step logic and the top level
// ----------------------------------------------------------------------------
package lmlt_pkg;

  localparam int unsigned ModeCntW = 13;
  localparam int unsigned LineCntW = 10;
  localparam int unsigned LineW    = 8;

  localparam logic [LineCntW-1:0] LINE_CYCLES   = 10'd456;
  localparam logic [LineW-1:0]    LINE_COUNT    = 8'd154;
  localparam logic [LineW-1:0]    VBLANK_LINE   = 8'd144;
  localparam logic [ModeCntW-1:0] HBLANK_CYCLES = 13'd204;
  localparam logic [ModeCntW-1:0] VBLANK_CYCLES = 13'd4560;
  localparam logic [ModeCntW-1:0] OAM_CYCLES    = 13'd80;
  localparam logic [ModeCntW-1:0] XFER_CYCLES   = 13'd172;

  // largest counter sums that can form before the counters clear
  localparam logic [ModeCntW-1:0] MODE_CNT_MAX = 13'd4814;
  localparam logic [LineCntW-1:0] LINE_CNT_MAX = 10'd710;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [ModeCntW-1:0] mode_cnt;
    logic [LineCntW-1:0] line_cnt;
    logic [LineW-1:0]    line;
  } timing_state_t;

endpackage
`default_nettype wire

/* design/lcd_mode_line_timing.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcd mode and line timing
// tracks scanline and display mode from counts of elapsed cpu cycles
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one request per cpu step: elapsed cycles and the lcd enable
//   bit. m_* returns one result per request: mode, line and a flag set when
//   the request advanced the scanline. results leave in request order.
//   a request is held in an input register, then the timing state and
//   result register update together through one add-and-compare step.
//   throughput is one request per cycle while the receiver is not
//   stalling, set by that single step.
//   when the receiver stalls, the result register holds and the input
//   register takes one more request; s_tready falls only when both are full.
//   reset (rst, synchronous) empties both registers and sets the timing
//   state to oam search, line zero, counters clear.
// ----------------------------------------------------------------------------
module lcd_mode_line_timing (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // cycles[7:0], lcd_enable[8], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // mode[1:0], line[9:2], line_advanced[10], zero pad
);
  import lmlt_pkg::*;

  logic          in_valid;
  logic [7:0]    in_cycles;
  logic          in_enable;
  logic          take;
  timing_state_t state;
  timing_state_t state_next;
  logic          advanced;
  mode_t         out_mode;
  logic [7:0]    out_line;
  logic          out_adv;

  assign take     = !m_tvalid || m_tready;
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cycles <= s_tdata[7:0];
      in_enable <= s_tdata[8];
    end
  end

  lmlt_step u_step (
    .cur        (state),
    .cycles     (in_cycles),
    .lcd_enable (in_enable),
    .nxt        (state_next),
    .advanced   (advanced)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode     <= MODE_OAM;
      state.mode_cnt <= '0;
      state.line_cnt <= '0;
      state.line     <= '0;
      m_tvalid       <= 1'b0;
    end else if (take) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      out_mode <= state_next.mode;
      out_line <= state_next.line;
      out_adv  <= advanced;
    end
  end

  assign m_tdata = {5'd0, out_adv, out_line, out_mode};

`ifndef SYNTHESIS
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    state.line < LINE_COUNT)
    else $error("scanline out of range");

  a_mode_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state.mode_cnt <= MODE_CNT_MAX)
    else $error("mode counter beyond its bound");

  a_line_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state.line_cnt <= LINE_CNT_MAX)
    else $error("line counter beyond its bound");

  a_handoff: assert property (@(posedge clk) disable iff (rst)
    (take && in_valid) |=> m_tvalid)
    else $error("request lost between input and result register");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(state))
    else $error("timing state moved while result stalled");
`endif

endmodule
`default_nettype wire

/* design/lmlt_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcd timing step
// next line and mode state for one request of elapsed cycles
// ----------------------------------------------------------------------------
module lmlt_step (
  input  wire lmlt_pkg::timing_state_t cur,
  input  wire logic [7:0]              cycles,
  input  wire logic                    lcd_enable,
  output lmlt_pkg::timing_state_t      nxt,
  output logic                         advanced
);
  import lmlt_pkg::*;

  logic [ModeCntW-1:0] mode_sum;
  logic [LineCntW-1:0] line_sum;
  logic [LineW-1:0]    line_inc;
  logic [LineW-1:0]    line_new;
  logic                line_wrap;
  logic                mode_done;
  mode_t               mode_new;

  assign mode_sum  = cur.mode_cnt + {{(ModeCntW-8){1'b0}}, cycles};
  assign line_sum  = cur.line_cnt + {{(LineCntW-8){1'b0}}, cycles};
  assign line_wrap = line_sum >= LINE_CYCLES;
  assign line_inc  = cur.line + 8'd1;
  assign line_new  = line_wrap ? ((line_inc >= LINE_COUNT) ? '0 : line_inc) : cur.line;

  always_comb begin
    mode_done = 1'b0;
    mode_new  = cur.mode;
    unique case (cur.mode)
      MODE_HBLANK: begin
        mode_done = mode_sum >= HBLANK_CYCLES;
        mode_new  = (line_new == VBLANK_LINE) ? MODE_VBLANK : MODE_OAM;
      end
      MODE_VBLANK: begin
        mode_done = mode_sum >= VBLANK_CYCLES;
        mode_new  = MODE_OAM;
      end
      MODE_OAM: begin
        mode_done = mode_sum >= OAM_CYCLES;
        mode_new  = MODE_XFER;
      end
      MODE_XFER: begin
        mode_done = mode_sum >= XFER_CYCLES;
        mode_new  = MODE_HBLANK;
      end
      default: begin
        mode_done = 1'b0;
        mode_new  = cur.mode;
      end
    endcase
  end

  always_comb begin
    nxt      = cur;
    advanced = 1'b0;
    if (lcd_enable) begin
      advanced     = line_wrap;
      nxt.line     = line_new;
      nxt.line_cnt = line_wrap ? '0 : line_sum;
      nxt.mode     = mode_done ? mode_new : cur.mode;
      nxt.mode_cnt = mode_done ? '0 : mode_sum;
    end
  end

endmodule
`default_nettype wire
